[hdl/recovery_deploy_sequencer_assert.svh]
// Assertion macros used by the recovery deploy sequencer core.
`ifndef RECOVERY_DEPLOY_SEQUENCER_ASSERT_SVH
`define RECOVERY_DEPLOY_SEQUENCER_ASSERT_SVH

// Antecedent in a cycle implies consequent in the same cycle.
`define RDS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle.
`define RDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rds_pkg.sv]
// Types and constants of the recovery deploy sequencer.
package rds_pkg;

    localparam int TIME_W   = 32;
    localparam int HEIGHT_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_USE_HEIGHT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USE_DELAY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_DELAY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_USE_MAX_TIME   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IGNITION_TIME  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EMERGENCY_DLY  = 3'd7;

    typedef struct packed {
        logic                       use_height;
        logic signed [HEIGHT_W-1:0] cmd_height;
        logic                       use_delay;
        logic [TIME_W-1:0]          cmd_delay_us;
        logic                       use_max_time;
        logic [TIME_W-1:0]          max_time_us;
        logic [TIME_W-1:0]          ignition_time_us;
        logic [TIME_W-1:0]          emergency_delay_us;
    } cfg_t;

    // one tick after the intake stage: mission time already resolved
    typedef struct packed {
        logic [TIME_W-1:0]          mission_t;
        logic                       apogee_seen;
        logic signed [HEIGHT_W-1:0] height;
        logic                       emergency;
    } tick_t;

    typedef struct packed {
        logic                       fire;
        logic                       apogee_latched;
        logic                       first_fire;
        logic                       pulse_complete;
        logic signed [HEIGHT_W-1:0] deployment_height;
    } result_t;

endpackage

[hdl/rds_cfg_regs.sv]
// Configuration register file of the recovery deploy sequencer.
module rds_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [rds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rds_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output rds_pkg::cfg_t                     cfg
);
    import rds_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_USE_HEIGHT:    cfg_next.use_height         = cfg_wdata[0];
                REG_CMD_HEIGHT:    cfg_next.cmd_height         = cfg_wdata[HEIGHT_W-1:0];
                REG_USE_DELAY:     cfg_next.use_delay          = cfg_wdata[0];
                REG_CMD_DELAY:     cfg_next.cmd_delay_us       = cfg_wdata[TIME_W-1:0];
                REG_USE_MAX_TIME:  cfg_next.use_max_time       = cfg_wdata[0];
                REG_MAX_TIME:      cfg_next.max_time_us        = cfg_wdata[TIME_W-1:0];
                REG_IGNITION_TIME: cfg_next.ignition_time_us   = cfg_wdata[TIME_W-1:0];
                REG_EMERGENCY_DLY: cfg_next.emergency_delay_us = cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/rds_intake.sv]
// Input register stage: captures a tick and resolves its mission time.
module rds_intake (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic                              advance,
    input  logic [rds_pkg::TIME_W-1:0]        now_us,
    input  logic                              liftoff,
    input  logic                              apogee_seen,
    input  logic signed [rds_pkg::HEIGHT_W-1:0] height,
    input  logic                              emergency,
    output logic                              stage_valid,
    output rds_pkg::tick_t                    stage
);
    import rds_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [TIME_W-1:0] mission_zero_reg;
    logic [TIME_W-1:0] mission_zero_next;
    tick_t             stage_reg;
    tick_t             stage_next;

    // mission clock restarts in arrival order, so it can move at capture
    always_comb begin
        mission_zero_next = mission_zero_reg;
        stage_next        = stage_reg;
        valid_next        = valid_reg;
        if (advance) begin
            valid_next = 1'b0;
        end
        if (accept) begin
            valid_next = 1'b1;
            if (liftoff) begin
                mission_zero_next = now_us;
            end
            stage_next.mission_t   = liftoff ? '0 : now_us - mission_zero_reg;
            stage_next.apogee_seen = apogee_seen;
            stage_next.height      = height;
            stage_next.emergency   = emergency;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg        <= 1'b0;
            mission_zero_reg <= '0;
        end else begin
            valid_reg        <= valid_next;
            mission_zero_reg <= mission_zero_next;
        end
    end

    always_ff @(posedge aclk) begin
        stage_reg <= stage_next;
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

[hdl/rds_core.sv]
// Apogee latch, deployment gates, fire pulse and result register.
module rds_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                m_tready,
    input  rds_pkg::tick_t      stage,
    input  rds_pkg::cfg_t       cfg,
    output logic                m_valid,
    output rds_pkg::result_t    result
);
    import rds_pkg::*;
    `include "recovery_deploy_sequencer_assert.svh"

    logic                       apogee_flag_reg, apogee_flag_next;
    logic [TIME_W-1:0]          apogee_time_reg, apogee_time_next;
    logic                       height_gate_reg, height_gate_next;
    logic [TIME_W-1:0]          height_gate_time_reg, height_gate_time_next;
    logic                       delay_gate_reg, delay_gate_next;
    logic                       triggered_reg, triggered_next;
    logic [TIME_W-1:0]          trigger_time_reg, trigger_time_next;
    logic signed [HEIGHT_W-1:0] held_height_reg, held_height_next;
    logic                       fire_level_reg, fire_level_next;
    logic                       first_reported_reg, first_reported_next;
    logic                       fired_once_reg, fired_once_next;
    logic                       done_flag_reg, done_flag_next;
    logic                       m_valid_reg, m_valid_next;
    result_t                    result_reg, result_next;

    logic              eff_use_height;
    logic              eff_use_delay;
    logic [TIME_W-1:0] eff_delay;
    logic [TIME_W-1:0] t;
    logic              go;
    logic              first;

    always_comb begin
        t              = stage.mission_t;
        eff_use_height = !stage.emergency && cfg.use_height;
        eff_use_delay  = stage.emergency || cfg.use_delay;
        eff_delay      = stage.emergency ? cfg.emergency_delay_us : cfg.cmd_delay_us;

        apogee_flag_next      = apogee_flag_reg;
        apogee_time_next      = apogee_time_reg;
        height_gate_next      = height_gate_reg;
        height_gate_time_next = height_gate_time_reg;
        delay_gate_next       = delay_gate_reg;
        triggered_next        = triggered_reg;
        trigger_time_next     = trigger_time_reg;
        held_height_next      = held_height_reg;
        fire_level_next       = fire_level_reg;
        first_reported_next   = first_reported_reg;
        fired_once_next       = fired_once_reg;
        done_flag_next        = done_flag_reg;
        go                    = 1'b0;
        first                 = 1'b0;

        // apogee: report or max-time limit, latched once
        if (!apogee_flag_reg &&
            (stage.apogee_seen || (cfg.use_max_time && t >= cfg.max_time_us))) begin
            apogee_flag_next = 1'b1;
            apogee_time_next = t;
        end

        if (apogee_flag_next) begin
            if (eff_use_height && !height_gate_reg && stage.height <= cfg.cmd_height) begin
                height_gate_next      = 1'b1;
                height_gate_time_next = t;
            end
            if (eff_use_delay && !delay_gate_reg) begin
                if (eff_use_height) begin
                    delay_gate_next = height_gate_next &&
                                      t >= height_gate_time_next + eff_delay;
                end else begin
                    delay_gate_next = t >= apogee_time_next + eff_delay;
                end
            end
            go = (!eff_use_height && !eff_use_delay) ||
                 (eff_use_height && !eff_use_delay && height_gate_next) ||
                 (!eff_use_height && eff_use_delay && delay_gate_next) ||
                 (eff_use_height && eff_use_delay && height_gate_next && delay_gate_next);
            if (triggered_reg || go) begin
                if (!triggered_reg) begin
                    triggered_next    = 1'b1;
                    trigger_time_next = t;
                    held_height_next  = stage.height;
                end
                fire_level_next = (t - trigger_time_next) < cfg.ignition_time_us;
            end
        end

        if (fire_level_next && !first_reported_reg) begin
            first_reported_next = 1'b1;
            first               = 1'b1;
        end
        if (!fired_once_reg && fire_level_next) begin
            fired_once_next = 1'b1;
        end else if (fired_once_reg && !fire_level_next) begin
            done_flag_next = 1'b1;
        end

        result_next.fire              = fire_level_next;
        result_next.apogee_latched    = apogee_flag_next;
        result_next.first_fire        = first;
        result_next.pulse_complete    = done_flag_next;
        result_next.deployment_height = held_height_next;

        m_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            apogee_flag_reg      <= 1'b0;
            apogee_time_reg      <= '0;
            height_gate_reg      <= 1'b0;
            height_gate_time_reg <= '0;
            delay_gate_reg       <= 1'b0;
            triggered_reg        <= 1'b0;
            trigger_time_reg     <= '0;
            held_height_reg      <= '0;
            fire_level_reg       <= 1'b0;
            first_reported_reg   <= 1'b0;
            fired_once_reg       <= 1'b0;
            done_flag_reg        <= 1'b0;
            m_valid_reg          <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (advance) begin
                apogee_flag_reg      <= apogee_flag_next;
                apogee_time_reg      <= apogee_time_next;
                height_gate_reg      <= height_gate_next;
                height_gate_time_reg <= height_gate_time_next;
                delay_gate_reg       <= delay_gate_next;
                triggered_reg        <= triggered_next;
                trigger_time_reg     <= trigger_time_next;
                held_height_reg      <= held_height_next;
                fire_level_reg       <= fire_level_next;
                first_reported_reg   <= first_reported_next;
                fired_once_reg       <= fired_once_next;
                done_flag_reg        <= done_flag_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign result  = result_reg;

    `RDS_ASSERT_IMPLIES(a_fire_needs_trigger, aclk, aresetn,
        fire_level_reg, triggered_reg && apogee_flag_reg,
        "fire asserted without trigger and apogee")
    `RDS_ASSERT_IMPLIES(a_done_after_fire, aclk, aresetn,
        done_flag_reg, fired_once_reg && first_reported_reg,
        "pulse complete without a prior fire")
    `RDS_ASSERT_NEXT(a_trigger_sticky, aclk, aresetn,
        triggered_reg, triggered_reg && apogee_flag_reg,
        "trigger or apogee latch dropped")
    `RDS_ASSERT_NEXT(a_state_moves_on_beat, aclk, aresetn,
        !advance, $stable(triggered_reg) && $stable(apogee_flag_reg),
        "sequencer state changed without a beat")

endmodule

[hdl/recovery_deploy_sequencer.sv]
// Top level of the recovery deploy sequencer.
// One input beat is one control tick and yields exactly one result beat.
// A beat is accepted every cycle unless the result side stalls. A result is
// registered in the input register, then in the result register, and the state
// update for a tick happens as it passes between those two registers.
// Backpressure on the result side stalls the input register, which in turn
// holds s_axis_tready low. Configuration writes take effect on the next cycle.
module recovery_deploy_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [rds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rds_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // now_us[31:0], liftoff[32], apogee_seen[33], height[57:34], emergency[58]
    input  logic [rds_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // fire[0], apogee_latched[1], first_fire[2], pulse_complete[3],
    // deployment_height[27:4]
    output logic [rds_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
    import rds_pkg::*;

    cfg_t    cfg;
    tick_t   stage;
    result_t result;
    logic    stage_valid;
    logic    accept;
    logic    advance;

    assign advance       = stage_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !stage_valid || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    rds_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rds_intake u_intake (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .advance     (advance),
        .now_us      (s_axis_tdata[31:0]),
        .liftoff     (s_axis_tdata[32]),
        .apogee_seen (s_axis_tdata[33]),
        .height      (s_axis_tdata[57:34]),
        .emergency   (s_axis_tdata[58]),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    rds_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .m_tready (m_axis_tready),
        .stage    (stage),
        .cfg      (cfg),
        .m_valid  (m_axis_tvalid),
        .result   (result)
    );

    assign m_axis_tdata = {4'b0000, result.deployment_height, result.pulse_complete,
                           result.first_fire, result.apogee_latched, result.fire};

endmodule

[bench/recovery_deploy_sequencer_test.sv]
// Self-checking bench for the recovery deploy sequencer: flight profiles plus random ticks.
module recovery_deploy_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rds_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;
    localparam int TICK_BUDGET = 1050;

    localparam logic [CFG_IDX_W-1:0] ALL_REGS [8] = '{
        REG_USE_HEIGHT, REG_CMD_HEIGHT, REG_USE_DELAY, REG_CMD_DELAY,
        REG_USE_MAX_TIME, REG_MAX_TIME, REG_IGNITION_TIME, REG_EMERGENCY_DLY
    };

    typedef enum {PICK_RANDOM, PICK_HIGH, PICK_LOW} pick_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    recovery_deploy_sequencer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // bench bookkeeping
    logic [S_TDATA_W-1:0] pending_ticks [$];
    result_t              expected_status [$];
    int                   failures     = 0;
    int                   results_seen = 0;
    int                   ticks_queued = 0;
    int                   send_gap     = 0;
    int                   stall_left   = 0;
    int                   quiet_cycles = 0;
    bit                   idle_on      = 1'b1;
    bit                   hold_request = 1'b0;
    bit                   hold_taken   = 1'b0;
    bit                   by_timer     = 1'b0;
    logic [1:0]           gate_mode    = '0;
    logic [TIME_W-1:0]    now_cursor   = '0;

    // sequencer shadow: settings and latched state
    cfg_t                       shadow_cfg    = '0;
    logic [TIME_W-1:0]          zero_us       = '0;
    logic [TIME_W-1:0]          apogee_at     = '0;
    logic [TIME_W-1:0]          hgate_at      = '0;
    logic [TIME_W-1:0]          trig_at       = '0;
    logic                       apogee_sealed = 1'b0;
    logic                       hgate         = 1'b0;
    logic                       dgate         = 1'b0;
    logic                       trig          = 1'b0;
    logic                       firing        = 1'b0;
    logic                       first_seen    = 1'b0;
    logic                       ever_fired    = 1'b0;
    logic                       pulse_done    = 1'b0;
    logic signed [HEIGHT_W-1:0] held_h        = '0;

    function automatic result_t advance_sequencer(input logic [S_TDATA_W-1:0] beat);
        logic [TIME_W-1:0]          now;
        logic [TIME_W-1:0]          t;
        logic [TIME_W-1:0]          dly;
        logic signed [HEIGHT_W-1:0] h;
        logic                       uh;
        logic                       ut;
        logic                       go;
        result_t                    r;
        now = beat[31:0];
        h   = beat[57:34];
        if (beat[32])
            zero_us = now;
        // emergency level forces delay-only with its own delay
        uh  = beat[58] ? 1'b0 : shadow_cfg.use_height;
        ut  = beat[58] ? 1'b1 : shadow_cfg.use_delay;
        dly = beat[58] ? shadow_cfg.emergency_delay_us : shadow_cfg.cmd_delay_us;
        t   = now - zero_us;
        if (!apogee_sealed &&
            (beat[33] || (shadow_cfg.use_max_time && t >= shadow_cfg.max_time_us))) begin
            apogee_sealed = 1'b1;
            apogee_at     = t;
        end
        if (apogee_sealed) begin
            if (uh && !hgate && h <= $signed(shadow_cfg.cmd_height)) begin
                hgate    = 1'b1;
                hgate_at = t;
            end
            if (ut && !dgate)
                dgate = uh ? (hgate && t >= hgate_at + dly) : (t >= apogee_at + dly);
            go = uh ? (hgate && (!ut || dgate)) : (!ut || dgate);
            if (trig || go) begin
                if (!trig) begin
                    trig    = 1'b1;
                    trig_at = t;
                    held_h  = h;
                end
                firing = (t - trig_at) < shadow_cfg.ignition_time_us;
            end
        end
        r.first_fire = firing && !first_seen;
        if (firing)
            first_seen = 1'b1;
        if (firing)
            ever_fired = 1'b1;
        else if (ever_fired)
            pulse_done = 1'b1;
        r.fire              = firing;
        r.apogee_latched    = apogee_sealed;
        r.pulse_complete    = pulse_done;
        r.deployment_height = held_h;
        return r;
    endfunction

    function automatic void check_status(input logic [M_TDATA_W-1:0] beat);
        result_t want;
        if (expected_status.size() == 0) begin
            $error("result beat %h with no tick outstanding", beat);
            failures++;
            return;
        end
        want = expected_status.pop_front();
        results_seen++;
        if (beat[0] !== want.fire) begin
            $error("fire: expected %0d, got %0d", want.fire, beat[0]);
            failures++;
        end
        if (beat[1] !== want.apogee_latched) begin
            $error("apogee_latched: expected %0d, got %0d", want.apogee_latched, beat[1]);
            failures++;
        end
        if (beat[2] !== want.first_fire) begin
            $error("first_fire: expected %0d, got %0d", want.first_fire, beat[2]);
            failures++;
        end
        if (beat[3] !== want.pulse_complete) begin
            $error("pulse_complete: expected %0d, got %0d", want.pulse_complete, beat[3]);
            failures++;
        end
        if (beat[27:4] !== want.deployment_height) begin
            $error("deployment_height: expected %0d, got %0d",
                   want.deployment_height, $signed(beat[27:4]));
            failures++;
        end
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int draw_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // tdata: now_us, liftoff, apogee_seen, height, emergency, 5 pad bits
    function automatic logic [S_TDATA_W-1:0] make_tick(input logic [TIME_W-1:0] now,
                                                        input logic lift, input logic seen,
                                                        input logic [HEIGHT_W-1:0] h,
                                                        input logic em);
        return {5'b0, em, h, seen, lift, now};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_value(input logic [CFG_IDX_W-1:0] idx,
                                                         input pick_t how);
        logic [CFG_DATA_W-1:0] v;
        case (how)
            PICK_HIGH: v = (idx == REG_CMD_HEIGHT) ? 32'h007F_FFFF : 32'hFFFF_FFFF;
            PICK_LOW:  v = (idx == REG_CMD_HEIGHT) ? 32'hFF80_0000 : 32'h0000_0000;
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = '0;
                    1:       v = '1;
                    2:       v = $urandom_range(0, 6000);
                    default: v = $urandom;
                endcase
                if (idx == REG_CMD_HEIGHT)
                    v = {{8{v[23]}}, v[23:0]};
            end
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_USE_HEIGHT:    shadow_cfg.use_height         = val[0];
            REG_CMD_HEIGHT:    shadow_cfg.cmd_height         = val[HEIGHT_W-1:0];
            REG_USE_DELAY:     shadow_cfg.use_delay          = val[0];
            REG_CMD_DELAY:     shadow_cfg.cmd_delay_us       = val;
            REG_USE_MAX_TIME:  shadow_cfg.use_max_time       = val[0];
            REG_MAX_TIME:      shadow_cfg.max_time_us        = val;
            REG_IGNITION_TIME: shadow_cfg.ignition_time_us   = val;
            REG_EMERGENCY_DLY: shadow_cfg.emergency_delay_us = val;
            default: ;
        endcase
    endtask

    // wait until every queued tick went in and every result came back
    task automatic drain();
        do
            @(posedge aclk);
        while (pending_ticks.size() != 0 || s_axis_tvalid || expected_status.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // pre-apogee extremes with settings at reset, so nothing may latch
    task automatic queue_opening_ticks();
        pending_ticks.push_back(make_tick(32'h0000_0000, 1'b1, 1'b0, 24'h00_0000, 1'b0));
        pending_ticks.push_back(make_tick(32'hFFFF_FFFF, 1'b0, 1'b0, 24'h7F_FFFF, 1'b1));
        pending_ticks.push_back(make_tick(32'h0000_0001, 1'b0, 1'b0, 24'h80_0000, 1'b0));
        pending_ticks.push_back(make_tick(32'hFFFF_FFFF, 1'b1, 1'b0, 24'hFF_FFFF, 1'b1));
        // mission time wraps through zero here
        pending_ticks.push_back(make_tick(32'h0000_0000, 1'b0, 1'b0, 24'h00_0001, 1'b0));
        pending_ticks.push_back(make_tick(32'h5555_5555, 1'b0, 1'b0, 24'h55_5555, 1'b1));
        pending_ticks.push_back(make_tick(32'hAAAA_AAAA, 1'b1, 1'b0, 24'hAA_AAAA, 1'b0));
        pending_ticks.push_back(make_tick(32'hAAAA_AAAB, 1'b0, 1'b0, 24'h00_0000, 1'b0));
        ticks_queued += 8;
    endtask

    // one ascent and descent; apogee by report or by timer, gates picked at random
    task automatic queue_flight();
        int   peak_i;
        int   drop_ticks;
        int   span;
        int   peak_h;
        int   cmd_h;
        int   rate;
        int   alt;
        int   em_from;
        int   em_to;
        int   i;
        logic seen;
        logic em;
        peak_i     = $urandom_range(25, 50);
        drop_ticks = $urandom_range(15, 40);
        span       = peak_i + drop_ticks + $urandom_range(60, 90);
        peak_h     = $urandom_range(20000, 2000000);
        cmd_h      = peak_h / 2 - $urandom_range(0, peak_h / 4);
        rate       = (peak_h - cmd_h) / (drop_ticks * drop_ticks) + 1;
        gate_mode  = 2'($urandom_range(0, 3));
        by_timer   = 1'($urandom_range(0, 1));
        write_reg(REG_USE_HEIGHT, {31'b0, gate_mode[0]});
        write_reg(REG_CMD_HEIGHT, cmd_h);
        write_reg(REG_USE_DELAY, {31'b0, gate_mode[1]});
        write_reg(REG_CMD_DELAY, $urandom_range(300, 3000));
        write_reg(REG_USE_MAX_TIME, by_timer ? 1 : $urandom_range(0, 1));
        write_reg(REG_MAX_TIME, by_timer ? peak_i * 100 : 32'hFFFF_FFFF);
        write_reg(REG_IGNITION_TIME, $urandom_range(500, 3000));
        write_reg(REG_EMERGENCY_DLY, $urandom_range(300, 3000));
        em_from = span;
        em_to   = span;
        if ($urandom_range(0, 2) == 0) begin
            em_from = peak_i + $urandom_range(0, drop_ticks);
            em_to   = em_from + $urandom_range(1, 30);
        end
        now_cursor = $urandom;
        for (i = 0; i < span; i++) begin
            if (i > 0)
                now_cursor += $urandom_range(50, 150);
            alt = peak_h - rate * (i - peak_i) * (i - peak_i) + int'($urandom_range(0, 100)) - 50;
            if (alt > 8388607)
                alt = 8388607;
            if (alt < -8388608)
                alt = -8388608;
            if (by_timer)
                seen = (i >= peak_i + 20) && ($urandom_range(0, 1) == 1);
            else
                seen = (i == peak_i) || (i > peak_i && $urandom_range(0, 1) == 1);
            em = (i >= em_from && i <= em_to) || ($urandom_range(0, 63) == 0);
            pending_ticks.push_back(make_tick(now_cursor, i == 0, seen,
                                              alt[HEIGHT_W-1:0], em));
        end
        ticks_queued += span;
    endtask

    // after deployment: clock restarts, jumps and noise on every field
    task automatic queue_random_ticks(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) == 0)
                now_cursor = $urandom;
            else
                now_cursor += $urandom_range(1, 3000);
            pending_ticks.push_back(make_tick(now_cursor, $urandom_range(0, 9) == 0,
                                              $urandom_range(0, 1) == 1,
                                              HEIGHT_W'($urandom),
                                              $urandom_range(0, 3) == 0));
        end
        ticks_queued += count;
    endtask

    // input side: one beat per slot, predictions taken at acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_status.push_back(advance_sequencer(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    s_axis_tdata  <= pending_ticks.pop_front();
                    s_axis_tvalid <= 1'b1;
                    send_gap = draw_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side: check each beat, random stalls, one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_status(m_axis_tdata);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    stall_left = draw_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("no beat moved for %0d cycles", QUIET_LIMIT);
                    $display("recovery_deploy_sequencer regression: fail");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [CFG_IDX_W-1:0] idx;
        int                   phase;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        queue_opening_ticks();
        drain();
        queue_flight();
        drain();
        phase = 0;
        while (ticks_queued < TICK_BUDGET) begin
            idle_on = (phase % 3 != 2);
            if (phase == 0) begin
                foreach (ALL_REGS[k])
                    write_reg(ALL_REGS[k], pick_value(ALL_REGS[k], PICK_HIGH));
                // receiver sits out a long stretch while ticks keep coming
                hold_request = 1'b1;
            end else if (phase == 1) begin
                foreach (ALL_REGS[k])
                    write_reg(ALL_REGS[k], pick_value(ALL_REGS[k], PICK_LOW));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    idx = ALL_REGS[3'($urandom_range(0, 7))];
                    write_reg(idx, pick_value(idx, PICK_RANDOM));
                end
            end
            queue_random_ticks($urandom_range(80, 130));
            drain();
            phase++;
        end
        repeat (10) @(posedge aclk);
        $display("covered %0d ticks over %0d setting phases, %0d results checked",
                 ticks_queued, phase + 2, results_seen);
        $display("flight apogee by %s, height gate %0d, delay gate %0d, fired %0d",
                 by_timer ? "timer" : "report", gate_mode[0], gate_mode[1], ever_fired);
        if (failures == 0) begin
            $display("recovery_deploy_sequencer regression: pass");
        end else begin
            $display("recovery_deploy_sequencer regression: fail");
        end
        $finish;
    end

endmodule
